// ===== design/dtnm_pkg.sv =====
// Shared types and constants for the deduplicating top-k neighbor list.
package dtnm_pkg;

	localparam int LIST_DEPTH_DEF = 16;

	localparam int KEEP_W = 7;
	localparam int DIST_W = 32;
	localparam int ID_W   = 32;
	localparam int RANK_W = 6;
	localparam int HIT_W  = 7;

	localparam logic [KEEP_W-1:0] KEEP_RESET = KEEP_W'(10);

	typedef enum logic [1:0] {
		FUNC_INSERT = 2'd0,
		FUNC_DUMP   = 2'd1,
		FUNC_CLEAR  = 2'd2
	} func_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_APPLY,
		ST_COUNT,
		ST_DUMP
	} state_t;

	typedef struct packed {
		logic [1:0]        func;
		logic [DIST_W-1:0] cand_dist;
		logic [ID_W-1:0]   cand_id;
		logic [DIST_W-1:0] threshold_dist;
	} cand_word_t;

	typedef struct packed {
		logic [RANK_W-1:0] rank;
		logic [DIST_W-1:0] out_dist;
		logic [ID_W-1:0]   out_id;
		logic              entry_valid;
		logic [HIT_W-1:0]  hit_count;
		logic              last;
	} res_word_t;

	// Broadcast from the controller to every cell.
	typedef struct packed {
		logic              capture;
		logic              apply;
		logic              rotate;
		logic              rm_match;
		logic [DIST_W-1:0] cand_dist;
		logic [ID_W-1:0]   id;
		logic [DIST_W-1:0] thr;
	} cell_bc_t;

	// Position of one cell relative to the current list length.
	typedef struct packed {
		logic in_list;
		logic is_tail;
		logic drop;
	} cell_pos_t;

	// Flags a cell reports back to the controller.
	typedef struct packed {
		logic lt;
		logic match;
		logic upd;
		logic le;
	} cell_stat_t;

endpackage

// ===== design/dedup_topk_neighbor_merge_top.sv =====
// Top level of the deduplicating top-k neighbor list: controller and cell chain.
//
//   channel   direction  handshake          word
//   cand      in         valid / stall      cand_word_t (func, distance, id, threshold)
//   res       out        valid / stall      res_word_t  (rank, entry, hit count, last)
//   cfg       in         valid / ready      keep_count, 7 bits
//
// An insert compares the candidate against every cell in ST_IDLE and then
// shifts the cells behind the insertion point in ST_APPLY. A clear finishes
// in ST_IDLE. A dump counts hits in ST_COUNT, then in ST_DUMP sends the result
// words (k at most, one for an empty list) while the result register is free;
// the list rotates through the head cell and is back in place when the dump
// ends. The block takes one word at a time, and the accepted candidate is held
// in a register for the shift. Reset clears the fill count, the state machine
// and the result valid, and sets keep_count to 10. No clearing pass is needed.
// A stalled result holds the dump where it is; cfg_ready is always high.
module dedup_topk_neighbor_merge_top import dtnm_pkg::*; #(
	parameter int LIST_DEPTH = LIST_DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cand_valid,
	output logic                  cand_stall,
	input  cand_word_t            cand_word,
	output logic                  res_valid,
	input  logic                  res_stall,
	output res_word_t             res_word,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [KEEP_W-1:0]     cfg_data
);

	localparam int CNT_W = $clog2(LIST_DEPTH + 1);
	localparam int IDX_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;

	state_t            state_q, state_d;
	logic [CNT_W-1:0]  fill_q, fill_d;
	logic [KEEP_W-1:0] keep_q;
	logic [IDX_W-1:0]  idx_q, idx_d;
	logic [HIT_W-1:0]  hits_q, hits_d;
	logic              res_valid_q;
	res_word_t         res_word_q, res_d;
	logic              load_res;
	logic [DIST_W-1:0] hold_dist_q;
	logic [ID_W-1:0]   hold_id_q;

	logic              cand_acc;
	logic              slot_free;
	logic [CNT_W-1:0]  k_eff;
	logic [CNT_W-1:0]  f;
	logic [CNT_W-1:0]  h;
	logic              any_match, any_upd, tail_lt;
	logic              drop_do;
	logic              is_last;

	cell_bc_t          bc;
	cell_pos_t         pos_v  [LIST_DEPTH];
	cell_stat_t        stat_v [LIST_DEPTH];
	logic [DIST_W-1:0] dist_v [LIST_DEPTH];
	logic [ID_W-1:0]   id_v   [LIST_DEPTH];
	logic              ge_v   [LIST_DEPTH];
	logic              rm_v   [LIST_DEPTH+1];
	logic [LIST_DEPTH:0] hit_t;

	assign cand_acc   = cand_valid && !cand_stall;
	assign cand_stall = (state_q != ST_IDLE);
	assign slot_free  = !res_valid_q || !res_stall;
	assign res_valid  = res_valid_q;
	assign res_word   = res_word_q;
	assign cfg_ready  = 1'b1;

	// Effective k: zero acts as one, anything above the depth acts as the depth.
	always_comb begin
		if (keep_q == '0) begin
			k_eff = CNT_W'(1);
		end else if (keep_q > KEEP_W'(LIST_DEPTH)) begin
			k_eff = CNT_W'(LIST_DEPTH);
		end else begin
			k_eff = CNT_W'(keep_q);
		end
	end

	// Live list length: entries beyond k are dropped on the next insert and
	// are never listed by a dump.
	assign f = (fill_q > k_eff) ? k_eff : fill_q;

	// Per-cell position flags and the reductions over cell flags.
	always_comb begin
		any_match = 1'b0;
		any_upd   = 1'b0;
		tail_lt   = 1'b0;
		hit_t     = '0;
		for (int j = 0; j < LIST_DEPTH; j++) begin
			pos_v[j].in_list = (CNT_W'(j) < f);
			pos_v[j].is_tail = ((CNT_W'(j) + CNT_W'(1)) == f);
			pos_v[j].drop    = drop_do && pos_v[j].is_tail;
			any_match = any_match | stat_v[j].match;
			any_upd   = any_upd | stat_v[j].upd;
			tail_lt   = tail_lt | (pos_v[j].is_tail && stat_v[j].lt);
			hit_t[j]  = stat_v[j].le;
		end
	end

	// The list is sorted, so the entries at or under the threshold form a
	// prefix; the hit count is the position where that prefix ends.
	always_comb begin
		h = '0;
		for (int j = 0; j < LIST_DEPTH; j++) begin
			if (hit_t[j] && !hit_t[j+1]) begin
				h = h | CNT_W'(j + 1);
			end
		end
	end

	assign is_last = ((CNT_W'(idx_q) + CNT_W'(1)) == f);

	// Next state and controls. The cells compare against the word on the
	// input while idle and shift in the held candidate afterwards, since the
	// sender may already present its next word.
	always_comb begin
		state_d      = state_q;
		fill_d       = fill_q;
		idx_d        = idx_q;
		hits_d       = hits_q;
		load_res     = 1'b0;
		res_d        = '0;
		bc.capture   = 1'b0;
		bc.apply     = 1'b0;
		bc.rotate    = 1'b0;
		bc.rm_match  = 1'b0;
		bc.cand_dist = (state_q == ST_IDLE) ? cand_word.cand_dist : hold_dist_q;
		bc.id        = (state_q == ST_IDLE) ? cand_word.cand_id : hold_id_q;
		bc.thr       = cand_word.threshold_dist;
		drop_do      = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (cand_acc) begin
					bc.capture = 1'b1;
					unique case (cand_word.func)
						FUNC_INSERT: state_d = ST_APPLY;
						FUNC_DUMP:   state_d = ST_COUNT;
						FUNC_CLEAR:  fill_d  = '0;
						default:     state_d = ST_IDLE;
					endcase
				end
			end
			ST_APPLY: begin
				// A held id moves only when the new distance is smaller; a new
				// id fills a free slot or replaces the worst entry it beats.
				fill_d  = f;
				state_d = ST_IDLE;
				if (any_match) begin
					if (any_upd) begin
						bc.apply    = 1'b1;
						bc.rm_match = 1'b1;
					end
				end else if (f < k_eff) begin
					bc.apply = 1'b1;
					fill_d   = f + CNT_W'(1);
				end else if ((f != '0) && tail_lt) begin
					bc.apply = 1'b1;
					drop_do  = 1'b1;
				end
			end
			ST_COUNT: begin
				hits_d  = HIT_W'(h);
				idx_d   = '0;
				state_d = ST_DUMP;
			end
			ST_DUMP: begin
				if (slot_free) begin
					load_res = 1'b1;
					if (f == '0) begin
						// Empty list: one result with only last set.
						res_d.last = 1'b1;
						state_d    = ST_IDLE;
					end else begin
						res_d.rank        = RANK_W'(idx_q);
						res_d.out_dist    = dist_v[0];
						res_d.out_id      = id_v[0];
						res_d.entry_valid = 1'b1;
						res_d.hit_count   = hits_q;
						res_d.last        = is_last;
						bc.rotate         = 1'b1;
						idx_d             = idx_q + IDX_W'(1);
						if (is_last) begin
							state_d = ST_IDLE;
						end
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			keep_q      <= KEEP_RESET;
			res_valid_q <= 1'b0;
		end else begin
			fill_q <= fill_d;
			if (cfg_valid && cfg_ready) begin
				keep_q <= cfg_data;
			end
			if (load_res) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_q  <= idx_d;
		hits_q <= hits_d;
		if (cand_acc) begin
			hold_dist_q <= cand_word.cand_dist;
			hold_id_q   <= cand_word.cand_id;
		end
		if (load_res) begin
			res_word_q <= res_d;
		end
	end

	// The cell chain: each cell sees its neighbors' entries, the insertion
	// flag of the cell before it, and whether a removal lies below it.
	assign rm_v[0] = 1'b0;

	for (genvar j = 0; j < LIST_DEPTH; j++) begin : g_cell
		logic              prev_ge_w;
		logic [DIST_W-1:0] prev_dist_w, next_dist_w;
		logic [ID_W-1:0]   prev_id_w, next_id_w;

		if (j == 0) begin : g_first
			assign prev_ge_w   = 1'b0;
			assign prev_dist_w = '0;
			assign prev_id_w   = '0;
		end else begin : g_mid
			assign prev_ge_w   = ge_v[j-1];
			assign prev_dist_w = dist_v[j-1];
			assign prev_id_w   = id_v[j-1];
		end

		if (j == LIST_DEPTH - 1) begin : g_end
			assign next_dist_w = dist_v[0];
			assign next_id_w   = id_v[0];
		end else begin : g_inner
			assign next_dist_w = dist_v[j+1];
			assign next_id_w   = id_v[j+1];
		end

		dtnm_cell u_cell (
			.clk        (clk),
			.bc         (bc),
			.pos        (pos_v[j]),
			.prev_ge    (prev_ge_w),
			.prev_dist  (prev_dist_w),
			.prev_id    (prev_id_w),
			.next_dist  (next_dist_w),
			.next_id    (next_id_w),
			.head_dist  (dist_v[0]),
			.head_id    (id_v[0]),
			.rm_below   (rm_v[j]),
			.rm_thru    (rm_v[j+1]),
			.ge         (ge_v[j]),
			.entry_dist (dist_v[j]),
			.id         (id_v[j]),
			.stat       (stat_v[j])
		);
	end

endmodule

// ===== design/dtnm_cell.sv =====
// One slot of the sorted neighbor list: holds an entry and its compare flags.
module dtnm_cell import dtnm_pkg::*; (
	input  logic              clk,
	input  cell_bc_t          bc,
	input  cell_pos_t         pos,
	input  logic              prev_ge,
	input  logic [DIST_W-1:0] prev_dist,
	input  logic [ID_W-1:0]   prev_id,
	input  logic [DIST_W-1:0] next_dist,
	input  logic [ID_W-1:0]   next_id,
	input  logic [DIST_W-1:0] head_dist,
	input  logic [ID_W-1:0]   head_id,
	input  logic              rm_below,
	output logic              rm_thru,
	output logic              ge,
	output logic [DIST_W-1:0] entry_dist,
	output logic [ID_W-1:0]   id,
	output cell_stat_t        stat
);

	logic [DIST_W-1:0] dist_q;
	logic [ID_W-1:0]   id_q;
	logic              lt_q;
	logic              eq_q;
	logic              dlt_q;
	logic              le_q;
	logic              rm_here;

	// Past the end of the list the candidate always orders before the slot.
	assign ge      = pos.in_list ? lt_q : 1'b1;
	assign rm_here = bc.apply && ((bc.rm_match && pos.in_list && eq_q) || pos.drop);
	assign rm_thru = rm_below | rm_here;

	assign entry_dist = dist_q;
	assign id         = id_q;

	assign stat.lt    = lt_q;
	assign stat.match = pos.in_list && eq_q;
	assign stat.upd   = pos.in_list && eq_q && dlt_q;
	assign stat.le    = pos.in_list && le_q;

	always_ff @(posedge clk) begin
		if (bc.capture) begin
			lt_q  <= (bc.cand_dist < dist_q) ||
				((bc.cand_dist == dist_q) && (bc.id < id_q));
			eq_q  <= (bc.id == id_q);
			dlt_q <= (bc.cand_dist < dist_q);
			le_q  <= (dist_q <= bc.thr);
		end
		if (bc.apply) begin
			if (ge && !prev_ge) begin
				dist_q <= bc.cand_dist;
				id_q   <= bc.id;
			end else if (prev_ge && !rm_below) begin
				dist_q <= prev_dist;
				id_q   <= prev_id;
			end
		end else if (bc.rotate && pos.in_list) begin
			if (pos.is_tail) begin
				dist_q <= head_dist;
				id_q   <= head_id;
			end else begin
				dist_q <= next_dist;
				id_q   <= next_id;
			end
		end
	end

endmodule
